/* sv/rlcum_pkg.sv */
// shared types and constants of the radio link unacknowledged-mode header builder
// no dependencies; used by every module of the block

package rlcum_pkg;

    // default limit on length indicators kept per pdu
    localparam int MAX_LI_DEF = 32;

    // bytes one item can produce, and the width of a byte count
    localparam int MAX_BYTES = 4;
    localparam int CNT_W     = 3;

    // queue between the front and the back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    // sequence number masks for the two modes
    localparam logic [9:0] SN5_MASK  = 10'h01f;
    localparam logic [9:0] SN10_MASK = 10'h3ff;

    // sequence number modes
    localparam logic SN_MODE_5  = 1'b0;
    localparam logic SN_MODE_10 = 1'b1;

    // header bytes caused by one input item
    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] data;
        logic [MAX_BYTES-1:0]      ends;
        logic [CNT_W-1:0]          count;
    } hdr_entry_t;

endpackage

/* sv/rlcum_front.sv */
// front of the header builder: takes items, keeps the pdu packing state and
// forms the header bytes of each item; depends on rlcum_pkg

module rlcum_front #(
    parameter int MAX_LI = rlcum_pkg::MAX_LI_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic                  cfg_wdata,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            framing_info,
    input  logic [10:0]           length_value,
    input  logic                  first_of_pdu,
    input  logic                  last_of_pdu,
    input  logic                  has_length,
    output logic                  q_push,
    output rlcum_pkg::hdr_entry_t q_entry,
    input  logic                  q_full
);

    localparam int LCW = $clog2(MAX_LI + 1);

    logic           sn_mode_reg;
    logic [9:0]     seq_number_reg, seq_number_next;
    logic [3:0]     pending_reg, pending_next;
    logic           odd_reg, odd_next;
    logic [LCW-1:0] length_count_reg, length_count_next;
    logic           accept;

    rlcum_pkg::hdr_entry_t entry;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    // form the bytes of one item and the state it leaves
    always_comb
    begin
        logic [rlcum_pkg::CNT_W-1:0] n_v;
        logic closes;
        logic e_bit;
        entry             = '0;
        n_v               = '0;
        closes            = 1'b0;
        e_bit             = 1'b0;
        seq_number_next   = seq_number_reg;
        pending_next      = first_of_pdu ? 4'h0 : pending_reg;
        odd_next          = first_of_pdu ? 1'b0 : odd_reg;
        length_count_next = first_of_pdu ? '0 : length_count_reg;

        // sequence number header
        if (first_of_pdu)
        begin
            if (sn_mode_reg == rlcum_pkg::SN_MODE_5)
            begin
                entry.data[0] = {framing_info, has_length, seq_number_reg[4:0]};
                entry.ends[0] = !has_length;
                n_v = 3'd1;
            end
            else
            begin
                entry.data[0] = {3'b000, framing_info, has_length, seq_number_reg[9:8]};
                entry.ends[0] = 1'b0;
                entry.data[1] = seq_number_reg[7:0];
                entry.ends[1] = !has_length;
                n_v = 3'd2;
            end
        end

        // length indicator packing, two per three bytes
        if (has_length)
        begin
            if (length_count_next < LCW'(MAX_LI))
            begin
                closes = last_of_pdu || (length_count_next == LCW'(MAX_LI - 1));
                e_bit  = !closes;
                if (!odd_next)
                begin
                    entry.data[n_v[1:0]] = {e_bit, length_value[10:4]};
                    entry.ends[n_v[1:0]] = 1'b0;
                    n_v = n_v + 3'd1;
                    pending_next = length_value[3:0];
                    odd_next     = 1'b1;
                    if (closes)
                    begin
                        entry.data[n_v[1:0]] = {length_value[3:0], 4'h0};
                        entry.ends[n_v[1:0]] = 1'b1;
                        n_v = n_v + 3'd1;
                        pending_next = 4'h0;
                        odd_next     = 1'b0;
                    end
                end
                else
                begin
                    entry.data[n_v[1:0]] = {pending_next, e_bit, length_value[10:8]};
                    entry.ends[n_v[1:0]] = 1'b0;
                    n_v = n_v + 3'd1;
                    entry.data[n_v[1:0]] = length_value[7:0];
                    entry.ends[n_v[1:0]] = closes;
                    n_v = n_v + 3'd1;
                    pending_next = 4'h0;
                    odd_next     = 1'b0;
                end
                length_count_next = length_count_next + LCW'(1);
            end
        end
        else if (!first_of_pdu && last_of_pdu && odd_next)
        begin
            // flush a half-filled pair
            entry.data[n_v[1:0]] = {pending_next, 4'h0};
            entry.ends[n_v[1:0]] = 1'b1;
            n_v = n_v + 3'd1;
            pending_next = 4'h0;
            odd_next     = 1'b0;
        end

        // close the pdu and advance the sequence number
        if (last_of_pdu)
        begin
            seq_number_next   = (seq_number_reg + 10'd1) &
                                ((sn_mode_reg == rlcum_pkg::SN_MODE_10) ?
                                 rlcum_pkg::SN10_MASK : rlcum_pkg::SN5_MASK);
            length_count_next = '0;
            odd_next          = 1'b0;
            pending_next      = 4'h0;
        end

        entry.count = n_v;
    end

    assign q_push  = accept && (entry.count != '0);
    assign q_entry = entry;

    // packing state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sn_mode_reg      <= rlcum_pkg::SN_MODE_5;
            seq_number_reg   <= '0;
            pending_reg      <= '0;
            odd_reg          <= 1'b0;
            length_count_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                sn_mode_reg <= cfg_wdata;
            end
            if (accept)
            begin
                seq_number_reg   <= seq_number_next;
                pending_reg      <= pending_next;
                odd_reg          <= odd_next;
                length_count_reg <= length_count_next;
            end
        end
    end

    // a pushed entry holds one to four bytes
    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> (q_entry.count <= rlcum_pkg::CNT_W'(rlcum_pkg::MAX_BYTES)))
        else $error("entry byte count out of range");

    // the kept indicator count never passes the limit
    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        length_count_reg <= LCW'(MAX_LI))
        else $error("length indicator count beyond limit");

endmodule

/* sv/rlcum_queue.sv */
// two-entry queue of header byte groups between front and back
// depends on rlcum_pkg

module rlcum_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  rlcum_pkg::hdr_entry_t push_entry,
    output logic                  full,
    input  logic                  pop,
    output logic                  not_empty,
    output rlcum_pkg::hdr_entry_t head
);

    rlcum_pkg::hdr_entry_t entries_reg [rlcum_pkg::Q_DEPTH];
    logic [rlcum_pkg::Q_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [rlcum_pkg::Q_CNT_W-1:0] count_reg;

    assign full      = (count_reg == rlcum_pkg::Q_CNT_W'(rlcum_pkg::Q_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entries_reg[rd_ptr_reg];

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + rlcum_pkg::Q_PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + rlcum_pkg::Q_PTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + rlcum_pkg::Q_CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - rlcum_pkg::Q_CNT_W'(1);
            end
        end
    end

    // no write into a full queue unless a read frees a place, no read from an empty one
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("queue underflow");

endmodule

/* sv/rlcum_back.sv */
// back of the header builder: sends the queued bytes one per cycle while out_ready is high and bytes are queued
// depends on rlcum_pkg

module rlcum_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_not_empty,
    input  rlcum_pkg::hdr_entry_t q_head,
    output logic                  q_pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [7:0]            header_byte,
    output logic                  header_end,
    output logic                  run_last
);

    rlcum_pkg::hdr_entry_t cur_reg;
    logic [1:0]            idx_reg;
    logic                  valid_reg;
    logic                  last_byte;

    assign last_byte = ({1'b0, idx_reg} == (cur_reg.count - rlcum_pkg::CNT_W'(1)));
    assign q_pop     = q_not_empty && (!valid_reg || (out_ready && last_byte));

    assign out_valid   = valid_reg;
    assign header_byte = cur_reg.data[idx_reg];
    assign header_end  = cur_reg.ends[idx_reg];
    assign run_last    = last_byte;

    // current group
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_head;
        end
    end

    // byte position and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else if (q_pop)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b1;
        end
        else if (valid_reg && out_ready)
        begin
            if (last_byte)
            begin
                valid_reg <= 1'b0;
            end
            else
            begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    // the byte position stays inside a non-empty group
    a_idx_in_group: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> ((cur_reg.count != '0) && ({1'b0, idx_reg} < cur_reg.count)))
        else $error("byte position outside group");

endmodule

/* sv/rlc_um_pdu_header_builder.sv */
// top level of the radio link unacknowledged-mode pdu header builder
// instantiates rlcum_front, rlcum_queue and rlcum_back; depends on rlcum_pkg

// Builds pdu headers as a byte stream. Each input item is one length
// indicator, or marks a pdu without indicators; it produces zero to four
// header bytes (sequence number header on the first item, packed length
// indicators after). The input takes an item in every cycle while the
// two-group queue behind the front has room; the output sends one byte per
// cycle while m_tready is high; an item yields four bytes at worst (a first
// item in 10-bit mode whose single indicator closes the header). tlast marks
// the final byte of a pdu header on the output, tuser the final byte caused
// by one item. The user writes sn_mode through cfg_we/cfg_wdata only while
// the block is idle; the block does not enforce it. No clearing pass after reset.

module rlc_um_pdu_header_builder #(
    parameter int MAX_LI = rlcum_pkg::MAX_LI_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_we,
    input  logic        cfg_wdata,     // sn_mode
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,       // framing_info[1:0], length_value[12:2], zero
    input  logic        s_tlast,       // last_of_pdu
    input  logic [1:0]  s_tuser,       // first_of_pdu[0], has_length[1]
    // header bytes
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,       // header_byte[7:0]
    output logic        m_tlast,       // header_end
    output logic [0:0]  m_tuser        // run_last[0]
);

    logic                  q_push;
    logic                  q_full;
    logic                  q_pop;
    logic                  q_not_empty;
    rlcum_pkg::hdr_entry_t q_in;
    rlcum_pkg::hdr_entry_t q_head;
    logic                  run_last;

    // classify items and form their bytes
    rlcum_front #(
        .MAX_LI(MAX_LI)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .framing_info (s_tdata[1:0]),
        .length_value (s_tdata[12:2]),
        .first_of_pdu (s_tuser[0]),
        .last_of_pdu  (s_tlast),
        .has_length   (s_tuser[1]),
        .q_push       (q_push),
        .q_entry      (q_in),
        .q_full       (q_full)
    );

    // decoupling queue
    rlcum_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .not_empty  (q_not_empty),
        .head       (q_head)
    );

    // byte serializer
    rlcum_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .header_byte (m_tdata),
        .header_end  (m_tlast),
        .run_last    (run_last)
    );

    assign m_tuser = run_last;

endmodule
